// ===== src/assert_macros.svh =====
// Assertion macros shared by the frame parser modules.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising edge outside reset
`define CFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check that a condition never holds
`define CFP_NEVER(lbl, cond, msg) \
  `CFP_ASSERT(lbl, !(cond), msg)
`else
`define CFP_ASSERT(lbl, prop, msg)
`define CFP_NEVER(lbl, cond, msg)
`endif
`endif

// ===== src/cfp_pkg.sv =====
// Shared types and constants of the checksum frame parser.
// No dependencies; used by every module of the block.
package cfp_pkg;

  localparam int MAX_PAYLOAD_DEF = 32;
  localparam int CFG_IDX_W       = 8;
  localparam int CFG_DATA_W      = 16;
  localparam int TIMER_W         = 15;

  localparam logic [7:0]         SOF_BYTE_RST = 8'd168;
  localparam logic [TIMER_W-1:0] TIMEOUT_RST  = 15'd500;

  // Sticky error flag positions
  localparam int ERR_NO_START = 0;
  localparam int ERR_CHECKSUM = 1;
  localparam int ERR_LENGTH   = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SOF_BYTE = 8'd0,
    CFG_TIMEOUT  = 8'd1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_DATA     = 3'd1,
    EV_BADSTART = 3'd2,
    EV_CHECKSUM = 3'd3,
    EV_TIMEOUT  = 3'd4,
    EV_LENGTH   = 3'd5
  } event_e;

  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_SRC   = 3'd1,
    PH_FUNC  = 3'd2,
    PH_LEN   = 3'd3,
    PH_BODY  = 3'd4
  } phase_e;

  typedef enum logic {
    CS_TAKE = 1'b0,
    CS_GIVE = 1'b1
  } ctrl_state_e;

  typedef struct packed {
    logic       op;
    logic [7:0] rx_byte;
  } cfp_in_t;

  typedef struct packed {
    event_e     event_res;
    logic [7:0] src_addr;
    logic [7:0] func_code;
    logic [5:0] payload_len;
    logic [4:0] data_index;
    logic [7:0] data_byte;
    logic       data_valid;
    logic       last;
    logic [2:0] sticky_errors;
  } cfp_out_t;

  // Controller to datapath
  typedef struct packed {
    logic step;     // take the input word
    logic advance;  // move to the next payload word
  } cfp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last;     // current result closes this input's burst
  } cfp_sts_t;

endpackage

// ===== src/cfp_datapath.sv =====
// Datapath of the frame parser: frame state, payload store, result register.
// Depends on cfp_pkg and assert_macros.svh.
`include "assert_macros.svh"
module cfp_datapath import cfp_pkg::*; #(
  parameter int MaxPayload = MAX_PAYLOAD_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfp_in_t               in_data_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  cfp_cmd_t              cmd_i,
  output cfp_sts_t              sts_o,
  output cfp_out_t              out_data_o
);

  localparam int LenW = $clog2(MaxPayload + 1);
  localparam int IdxW = (MaxPayload > 1) ? $clog2(MaxPayload) : 1;

  logic [7:0]         start_sym_q;
  logic [TIMER_W-1:0] timeout_q;

  phase_e             phase_q, phase_d;
  logic [7:0]         sum_q, sum_d;
  logic [LenW-1:0]    pos_q, pos_d;
  logic [7:0]         src_q, src_d;
  logic [7:0]         func_q, func_d;
  logic [LenW-1:0]    len_q, len_d;
  logic [TIMER_W-1:0] idle_q, idle_d;
  logic [2:0]         flags_q, flags_d;
  event_e             ev_q, ev_d;
  logic               wr_en;
  logic [IdxW-1:0]    idx_q;
  logic [IdxW-1:0]    rd_addr;
  logic [7:0]         rd_q;
  logic [7:0]         mem_q [MaxPayload];
  logic [7:0]         sum_add;
  logic               is_data;
  logic               has_bytes;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_sym_q <= SOF_BYTE_RST;
      timeout_q   <= TIMEOUT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SOF_BYTE: start_sym_q <= cfg_data_i[7:0];
        CFG_TIMEOUT:  timeout_q   <= cfg_data_i[TIMER_W-1:0];
        default: ;
      endcase
    end
  end

  // Work out the frame state and event caused by one input word
  always_comb begin
    phase_d = phase_q;
    sum_d   = sum_q;
    pos_d   = pos_q;
    src_d   = src_q;
    func_d  = func_q;
    len_d   = len_q;
    idle_d  = idle_q;
    flags_d = flags_q;
    ev_d    = EV_NONE;
    wr_en   = 1'b0;
    sum_add = sum_q + in_data_i.rx_byte;
    if (in_data_i.op) begin
      if (phase_q != PH_START) begin
        if (idle_q >= timeout_q) begin
          phase_d = PH_START;
          sum_d   = '0;
          pos_d   = '0;
          idle_d  = '0;
          ev_d    = EV_TIMEOUT;
        end else begin
          idle_d = idle_q + 1'b1;
        end
      end
    end else if (phase_q == PH_START) begin
      idle_d = '0;
      if (in_data_i.rx_byte == start_sym_q) begin
        phase_d = PH_SRC;
        sum_d   = in_data_i.rx_byte;
      end else begin
        flags_d[ERR_NO_START] = 1'b1;
        sum_d = '0;
        pos_d = '0;
        ev_d  = EV_BADSTART;
      end
    end else begin
      sum_d  = sum_add;
      idle_d = '0;
      unique case (phase_q)
        PH_SRC: begin
          src_d   = in_data_i.rx_byte;
          phase_d = PH_FUNC;
        end
        PH_FUNC: begin
          func_d  = in_data_i.rx_byte;
          phase_d = PH_LEN;
        end
        PH_LEN: begin
          if (in_data_i.rx_byte > 8'(MaxPayload)) begin
            flags_d[ERR_LENGTH] = 1'b1;
            phase_d = PH_START;
            sum_d   = '0;
            pos_d   = '0;
            ev_d    = EV_LENGTH;
          end else begin
            len_d   = in_data_i.rx_byte[LenW-1:0];
            pos_d   = '0;
            phase_d = PH_BODY;
          end
        end
        PH_BODY: begin
          if (pos_q == len_q) begin
            // checksum word closes the frame
            phase_d = PH_START;
            sum_d   = '0;
            pos_d   = '0;
            if (sum_add == 8'd0) begin
              ev_d = EV_DATA;
            end else begin
              flags_d[ERR_CHECKSUM] = 1'b1;
              ev_d = EV_CHECKSUM;
            end
          end else begin
            wr_en = 1'b1;
            pos_d = pos_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Frame state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      sum_q   <= '0;
      pos_q   <= '0;
      src_q   <= '0;
      func_q  <= '0;
      len_q   <= '0;
      idle_q  <= '0;
      flags_q <= '0;
      ev_q    <= EV_NONE;
      idx_q   <= '0;
    end else if (cmd_i.step) begin
      phase_q <= phase_d;
      sum_q   <= sum_d;
      pos_q   <= pos_d;
      src_q   <= src_d;
      func_q  <= func_d;
      len_q   <= len_d;
      idle_q  <= idle_d;
      flags_q <= flags_d;
      ev_q    <= ev_d;
      idx_q   <= '0;
    end else if (cmd_i.advance) begin
      idx_q <= idx_q + 1'b1;
    end
  end

  // Payload store; read one word ahead of the output
  assign rd_addr = cmd_i.step    ? '0 :
                   cmd_i.advance ? idx_q + 1'b1 : idx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.step && wr_en) begin
      mem_q[pos_q[IdxW-1:0]] <= in_data_i.rx_byte;
    end
    rd_q <= mem_q[rd_addr];
  end

  // Build the result word
  assign is_data   = (ev_q == EV_DATA);
  assign has_bytes = is_data && (len_q != '0);

  assign sts_o.last = !has_bytes || ((LenW'(idx_q) + LenW'(1)) == len_q);

  always_comb begin
    out_data_o               = '0;
    out_data_o.event_res     = ev_q;
    out_data_o.last          = sts_o.last;
    out_data_o.sticky_errors = flags_q;
    if (is_data) begin
      out_data_o.src_addr    = src_q;
      out_data_o.func_code   = func_q;
      out_data_o.payload_len = 6'(len_q);
    end
    if (has_bytes) begin
      out_data_o.data_index = 5'(idx_q);
      out_data_o.data_byte  = rd_q;
      out_data_o.data_valid = 1'b1;
    end
  end

  `CFP_ASSERT(a_flags_sticky, (flags_q | $past(flags_q)) == flags_q, "sticky flag cleared")
  `CFP_ASSERT(a_adv_data, cmd_i.advance |-> has_bytes, "advance outside a payload burst")
  `CFP_ASSERT(a_idle_tick, (cmd_i.step && in_data_i.op && phase_q == PH_START) |=>
              ev_q == EV_NONE, "tick while idle reported an event")

endmodule

// ===== src/cfp_ctrl.sv =====
// Controller of the frame parser: input/output handshake sequencing.
// Depends on cfp_pkg and assert_macros.svh.
`include "assert_macros.svh"
module cfp_ctrl import cfp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  cfp_sts_t sts_i,
  output cfp_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CS_TAKE: if (in_valid_i) state_d = CS_GIVE;
      CS_GIVE: if (out_ready_i && sts_i.last) state_d = CS_TAKE;
      default: state_d = CS_TAKE;
    endcase
  end

  // Handshakes and datapath commands
  always_comb begin
    in_ready_o    = 1'b0;
    out_valid_o   = 1'b0;
    cmd_o.step    = 1'b0;
    cmd_o.advance = 1'b0;
    unique case (state_q)
      CS_TAKE: begin
        in_ready_o = 1'b1;
        cmd_o.step = in_valid_i;
      end
      CS_GIVE: begin
        out_valid_o   = 1'b1;
        cmd_o.advance = out_ready_i && !sts_i.last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_TAKE;
    end else begin
      state_q <= state_d;
    end
  end

  `CFP_ASSERT(a_step_result, cmd_o.step |=> out_valid_o, "input word gave no result")
  `CFP_ASSERT(a_last_free, (out_valid_o && out_ready_i && sts_i.last) |=> in_ready_o, "not ready after last result")
  `CFP_ASSERT(a_burst_hold, cmd_o.advance |=> out_valid_o && !in_ready_o, "burst broke off early")
  `CFP_NEVER(a_step_adv, cmd_o.step && cmd_o.advance, "step and advance together")

endmodule

// ===== src/checksum_frame_parser.sv =====
// Top level of the start/length/checksum frame parser.
// Depends on cfp_pkg, cfp_ctrl and cfp_datapath.
//
// Input channel (in_valid_i/in_ready_o/in_data_i): each word is a received
// byte or a millisecond tick. Output channel (out_valid_o/out_ready_i/
// out_data_o) returns one result word per input word, or one word per
// payload byte when the input completes a good frame, the final one marked
// by last. Configuration (cfg_*) sets the start symbol and the timeout and
// is always ready; write it only while the block is idle.
// Latency: the first result is shown the cycle after the input is taken.
// Throughput: one input word is taken, then its results are given; no new
// input is taken until its last result is accepted. A payload burst gives
// one byte per cycle when not stalled, the store being read one word ahead.
// When the receiver stalls the current result holds and no input is taken.
// Reset clears the frame state, sticky flags and configuration to defaults;
// the payload store is not cleared and needs no clearing pass.
module checksum_frame_parser import cfp_pkg::*; #(
  parameter int MaxPayload = MAX_PAYLOAD_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  cfp_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output cfp_out_t              out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfp_cmd_t cmd;
  cfp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  cfp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cfp_datapath #(
    .MaxPayload (MaxPayload)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (out_data_o)
  );

endmodule
